[rtl/core/olsir_pkg.sv]
// Shared types and constants for the ordered list with shift insert and remove.
`default_nettype none
package olsir_pkg;

  // Fixed field widths of the command and result beats.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;

  // Default number of entries the list holds.
  localparam int unsigned OLSIR_CAPACITY = 64;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH       = 3'd0,
    CMD_POP        = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_INSERT_MID = 3'd4,
    CMD_REMOVE_MID = 3'd5,
    CMD_READ_AT    = 3'd6
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Source of an index loaded into the walk pointer or the target register.
  typedef enum logic [1:0] {
    SRC_COUNT,
    SRC_POS,
    SRC_HALF
  } src_sel_e;

  // Memory read address selection.
  typedef enum logic [1:0] {
    RD_PTR_M1,
    RD_PTR_P1,
    RD_POS,
    RD_CNT_M1
  } rd_sel_e;

  // Memory write selection: shifted word at the pointer, or new word at the target.
  typedef enum logic {
    WR_PTR_RD,
    WR_TGT_WORD
  } wr_sel_e;

  // Result data selection.
  typedef enum logic [1:0] {
    DATA_ZERO,
    DATA_ONES,
    DATA_RD
  } data_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      word_ld;
    logic      ptr_ld;
    src_sel_e  ptr_sel;
    logic      tgt_ld;
    src_sel_e  tgt_sel;
    logic      ptr_inc;
    logic      ptr_dec;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_ld;
    status_e   res_status;
    data_sel_e res_data_sel;
  } dp_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic ptr_gt_tgt;
    logic ptr_p1_lt_cnt;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/ordered_list_shift_insert_remove.sv]
// Commands answered at once (errors, push/insert into a full list, empty pop, unknown command) go
// from accept straight to the done_o beat; pop and read_at first read the entry, and an insert
// or remove at index first shifts the entries between the index and the end of the list.
// Each shifted entry is read and then written, as the controller never overlaps the two.
// busy drops in the cycle of the done_o beat, so the next command may be accepted then.
// Reset clears the count and the controller; entry memory contents are kept and unused.
`default_nettype none
module ordered_list_shift_insert_remove #(
  parameter int unsigned CAPACITY = olsir_pkg::OLSIR_CAPACITY
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [olsir_pkg::CMD_W-1:0]         cmd_i,
  input  wire logic [olsir_pkg::POS_W-1:0]         position_i,
  input  wire logic signed [olsir_pkg::DATA_W-1:0] item_value_i,
  output logic                                     done_o,
  output logic signed [olsir_pkg::DATA_W-1:0]      data_out_o,
  output logic [olsir_pkg::POS_W-1:0]              entry_count_o,
  output logic [olsir_pkg::STAT_W-1:0]             status_o
);
  import olsir_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Command sequencing.
  olsir_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd),
    .done_o   (done_o)
  );

  // Storage and result datapath.
  olsir_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .data_out_o    (data_out_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire

[rtl/core/olsir_dp.sv]
// Datapath: entry memory, count, walk pointer, target index and result registers.
`default_nettype none
module olsir_dp #(
  parameter int unsigned CAPACITY = olsir_pkg::OLSIR_CAPACITY
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire olsir_pkg::dp_cmd_t                cmd_i,
  output olsir_pkg::dp_stat_t                    stat_o,
  input  wire logic [olsir_pkg::POS_W-1:0]       position_i,
  input  wire logic signed [olsir_pkg::DATA_W-1:0] item_value_i,
  output logic signed [olsir_pkg::DATA_W-1:0]    data_out_o,
  output logic [olsir_pkg::POS_W-1:0]            entry_count_o,
  output logic [olsir_pkg::STAT_W-1:0]           status_o
);
  import olsir_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  tgt_q, tgt_d;
  logic [DATA_W-1:0] word_q;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] data_q;
  status_e           status_q;
  logic [DATA_W-1:0] mem_q [CAPACITY];

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  cnt_wide;
  logic [CNT_W-1:0]  pos_cnt;
  logic [CNT_W-1:0]  half_cnt;
  logic [CNT_W:0]    ptr_p1_wide;
  logic [CNT_W-1:0]  ptr_m1;
  logic [CNT_W-1:0]  ptr_p1;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  rd_addr_full;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Index arithmetic on the position, the count and the walk pointer.
  assign pos_ext     = CMP_W'(position_i);
  assign cnt_ext     = CMP_W'(count_q);
  assign pos_cnt     = CNT_W'(pos_ext);
  assign half_cnt    = count_q >> 1;
  assign ptr_p1_wide = {1'b0, ptr_q} + {{CNT_W{1'b0}}, 1'b1};
  assign ptr_m1      = ptr_q - CNT_W'(1);
  assign ptr_p1      = ptr_p1_wide[CNT_W-1:0];
  assign cnt_m1      = count_q - CNT_W'(1);

  // Flags the controller decides on.
  assign stat_o.full          = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty         = (count_q == '0);
  assign stat_o.pos_gt_cnt    = (pos_ext > cnt_ext);
  assign stat_o.pos_ge_cnt    = (pos_ext >= cnt_ext);
  assign stat_o.ptr_gt_tgt    = (ptr_q > tgt_q);
  assign stat_o.ptr_p1_lt_cnt = (ptr_p1_wide < {1'b0, count_q});

  // Index source selection for the pointer and target loads.
  always_comb begin
    unique case (cmd_i.ptr_sel)
      SRC_COUNT: ptr_d = count_q;
      SRC_POS:   ptr_d = pos_cnt;
      SRC_HALF:  ptr_d = half_cnt;
      default:   ptr_d = count_q;
    endcase
    unique case (cmd_i.tgt_sel)
      SRC_COUNT: tgt_d = count_q;
      SRC_POS:   tgt_d = pos_cnt;
      SRC_HALF:  tgt_d = half_cnt;
      default:   tgt_d = count_q;
    endcase
  end

  // Count update.
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  // Control registers: the count is the only architectural state that needs reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Walk pointer, target and latched word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr_ld) begin
      ptr_q <= ptr_d;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_p1;
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_m1;
    end
    if (cmd_i.tgt_ld) begin
      tgt_q <= tgt_d;
    end
    if (cmd_i.word_ld) begin
      word_q <= item_value_i;
    end
  end

  // Memory address and write data selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PTR_M1: rd_addr_full = ptr_m1;
      RD_PTR_P1: rd_addr_full = ptr_p1;
      RD_POS:    rd_addr_full = pos_cnt;
      RD_CNT_M1: rd_addr_full = cnt_m1;
      default:   rd_addr_full = cnt_m1;
    endcase
    unique case (cmd_i.wr_sel)
      WR_PTR_RD: begin
        wr_addr = ptr_q[IDX_W-1:0];
        wr_data = rd_q;
      end
      WR_TGT_WORD: begin
        wr_addr = tgt_q[IDX_W-1:0];
        wr_data = word_q;
      end
      default: begin
        wr_addr = ptr_q[IDX_W-1:0];
        wr_data = rd_q;
      end
    endcase
  end
  assign rd_addr = rd_addr_full[IDX_W-1:0];

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      status_q <= cmd_i.res_status;
      unique case (cmd_i.res_data_sel)
        DATA_ZERO: data_q <= '0;
        DATA_ONES: data_q <= '1;
        DATA_RD:   data_q <= rd_q;
        default:   data_q <= '0;
      endcase
    end
  end

  // The reported count is the low bits of the internal count.
  assign cnt_wide      = CMP_W'(count_q);
  assign entry_count_o = cnt_wide[POS_W-1:0];
  assign data_out_o    = data_q;
  assign status_o      = status_q;

endmodule
`default_nettype wire

[rtl/core/olsir_ctrl.sv]
// Controller state machine that sequences each command over the datapath.
`default_nettype none
module olsir_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [olsir_pkg::CMD_W-1:0] cmd_i,
  input  wire olsir_pkg::dp_stat_t         stat_i,
  output olsir_pkg::dp_cmd_t               dp_cmd_o,
  output logic                             done_o
);
  import olsir_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_WR,
    S_REM,
    S_REM_WR,
    S_POP,
    S_READ
  } state_e;

  state_e  state_q, state_d;
  logic    done_q;
  dp_cmd_t c;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    c       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          c.word_ld = 1'b1;
          unique case (cmd_e'(cmd_i))
            CMD_PUSH: begin
              if (stat_i.full) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_FULL;
              end else begin
                c.ptr_ld  = 1'b1;
                c.ptr_sel = SRC_COUNT;
                c.tgt_ld  = 1'b1;
                c.tgt_sel = SRC_COUNT;
                state_d   = S_INS;
              end
            end
            CMD_POP: begin
              if (stat_i.empty) begin
                c.res_ld       = 1'b1;
                c.res_status   = ST_EMPTY;
                c.res_data_sel = DATA_ONES;
              end else begin
                c.rd_en  = 1'b1;
                c.rd_sel = RD_CNT_M1;
                state_d  = S_POP;
              end
            end
            CMD_INSERT_AT: begin
              if (stat_i.pos_gt_cnt) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_RANGE;
              end else if (stat_i.full) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_FULL;
              end else begin
                c.ptr_ld  = 1'b1;
                c.ptr_sel = SRC_COUNT;
                c.tgt_ld  = 1'b1;
                c.tgt_sel = SRC_POS;
                state_d   = S_INS;
              end
            end
            CMD_REMOVE_AT: begin
              if (stat_i.pos_ge_cnt) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_RANGE;
              end else begin
                c.ptr_ld  = 1'b1;
                c.ptr_sel = SRC_POS;
                state_d   = S_REM;
              end
            end
            CMD_INSERT_MID: begin
              if (stat_i.full) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_FULL;
              end else begin
                c.ptr_ld  = 1'b1;
                c.ptr_sel = SRC_COUNT;
                c.tgt_ld  = 1'b1;
                c.tgt_sel = SRC_HALF;
                state_d   = S_INS;
              end
            end
            CMD_REMOVE_MID: begin
              if (stat_i.empty) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_EMPTY;
              end else begin
                c.ptr_ld  = 1'b1;
                c.ptr_sel = SRC_HALF;
                state_d   = S_REM;
              end
            end
            CMD_READ_AT: begin
              if (stat_i.pos_ge_cnt) begin
                c.res_ld     = 1'b1;
                c.res_status = ST_RANGE;
              end else begin
                c.rd_en  = 1'b1;
                c.rd_sel = RD_POS;
                state_d  = S_READ;
              end
            end
            default: begin
              // An unknown command changes nothing and answers OK.
              c.res_ld = 1'b1;
            end
          endcase
        end
      end

      // Shift up: move entry ptr-1 to ptr until the target slot is free.
      S_INS: begin
        if (stat_i.ptr_gt_tgt) begin
          c.rd_en  = 1'b1;
          c.rd_sel = RD_PTR_M1;
          state_d  = S_INS_WR;
        end else begin
          c.wr_en   = 1'b1;
          c.wr_sel  = WR_TGT_WORD;
          c.cnt_inc = 1'b1;
          c.res_ld  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_INS_WR: begin
        c.wr_en   = 1'b1;
        c.wr_sel  = WR_PTR_RD;
        c.ptr_dec = 1'b1;
        state_d   = S_INS;
      end

      // Shift down: move entry ptr+1 to ptr until the last entry is reached.
      S_REM: begin
        if (stat_i.ptr_p1_lt_cnt) begin
          c.rd_en  = 1'b1;
          c.rd_sel = RD_PTR_P1;
          state_d  = S_REM_WR;
        end else begin
          c.cnt_dec = 1'b1;
          c.res_ld  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_REM_WR: begin
        c.wr_en   = 1'b1;
        c.wr_sel  = WR_PTR_RD;
        c.ptr_inc = 1'b1;
        state_d   = S_REM;
      end

      // The read word is in the datapath read register.
      S_POP: begin
        c.cnt_dec      = 1'b1;
        c.res_ld       = 1'b1;
        c.res_data_sel = DATA_RD;
        state_d        = S_IDLE;
      end
      S_READ: begin
        c.res_ld       = 1'b1;
        c.res_data_sel = DATA_RD;
        state_d        = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= c.res_ld;
    end
  end

  assign dp_cmd_o = c;
  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the ordered list with shift insert and remove.
`default_nettype none
module tb_top;
  import olsir_pkg::*;

  localparam int unsigned CAPACITY   = OLSIR_CAPACITY;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 4;

  // The one code the block has no name for; it must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

  // One answer beat as the list should produce it.
  typedef struct {
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  count;
    status_e           status;
  } list_reply_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         cmd_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] item_value_i = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [POS_W-1:0]         entry_count_o;
  logic [STAT_W-1:0]        status_o;

  // Shadow copy of the list contents and length.
  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int unsigned       shadow_count = 0;

  list_reply_t pending_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_cycles = 0;

  ordered_list_shift_insert_remove uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .done_o        (done_o),
    .data_out_o    (data_out_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  always #6 clk_i = ~clk_i;

  // Open a slot at the given index, moving later entries up by one.
  function automatic void shadow_insert(int unsigned at, logic [DATA_W-1:0] word);
    for (int unsigned i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[at] = word;
    shadow_count++;
  endfunction

  // Close the slot at the given index, moving later entries down by one.
  function automatic void shadow_remove(int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_count--;
  endfunction

  // Apply one command to the shadow list and return the answer it should give.
  function automatic list_reply_t apply_list_command(logic [CMD_W-1:0] op,
                                                     logic [POS_W-1:0] pos,
                                                     logic [DATA_W-1:0] word);
    list_reply_t r;
    r.data = '0;
    r.status = ST_OK;
    case (op)
      CMD_PUSH: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else shadow_insert(shadow_count, word);
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.data = '1;
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          r.data = shadow_entries[shadow_count];
        end
      end
      CMD_INSERT_AT: begin
        // The index test takes priority over the full test.
        if (pos > shadow_count) r.status = ST_RANGE;
        else if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else shadow_insert(32'(pos), word);
      end
      CMD_REMOVE_AT: begin
        if (pos >= shadow_count) r.status = ST_RANGE;
        else shadow_remove(32'(pos));
      end
      CMD_INSERT_MID: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else shadow_insert(shadow_count / 2, word);
      end
      CMD_REMOVE_MID: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_remove(shadow_count / 2);
      end
      CMD_READ_AT: begin
        if (pos >= shadow_count) r.status = ST_RANGE;
        else r.data = shadow_entries[pos];
      end
      default: begin
      end
    endcase
    r.count = shadow_count[POS_W-1:0];
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one command beat, with random idle cycles in front of it.
  task automatic send_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] word);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= op;
    position_i <= pos;
    item_value_i <= word;
    do @(posedge clk_i); while (busy);
    pending_replies.push_back(apply_list_command(op, pos, word));
  endtask

  // Random word, with the sign and edge values picked now and then.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random index over the whole position field.
  function automatic logic [POS_W-1:0] pick_any_position();
    return POS_W'($urandom_range(127));
  endfunction

  // Index that is mostly valid for the command, sometimes anything at all.
  function automatic logic [POS_W-1:0] pick_position(logic [CMD_W-1:0] op);
    if ($urandom_range(99) < 15 || shadow_count == 0) return pick_any_position();
    if (op == CMD_INSERT_AT) return POS_W'($urandom_range(shadow_count, 0));
    return POS_W'($urandom_range(shadow_count - 1, 0));
  endfunction

  // Compare each answer beat with the oldest pending answer.
  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("answer beat with no command pending");
      end else begin
        want = pending_replies.pop_front();
        if (data_out_o !== want.data) begin
          report_mismatch($sformatf("mismatch on data_out: got %h, expected %h",
                                    data_out_o, want.data));
        end
        if (entry_count_o !== want.count) begin
          report_mismatch($sformatf("mismatch on entry_count: got %0d, expected %0d",
                                    entry_count_o, want.count));
        end
        if (status_o !== want.status) begin
          report_mismatch($sformatf("mismatch on status: got %0d, expected %0d",
                                    status_o, want.status));
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, stall_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Empty-list errors, index errors, the unknown code and shifts at both ends.
  task automatic test_edge_cases();
    send_command(CMD_POP, 7'd0, 32'hAAAA_AAAA);
    send_command(CMD_REMOVE_MID, 7'd127, 32'h5555_5555);
    send_command(CMD_REMOVE_AT, 7'd0, '0);
    send_command(CMD_READ_AT, 7'd0, '1);
    send_command(CMD_INSERT_AT, 7'd1, 32'h1234_5678);
    send_command(CMD_UNKNOWN, 7'd127, '1);
    send_command(CMD_INSERT_AT, 7'd0, 32'h8000_0000);
    send_command(CMD_PUSH, 7'd127, 32'h7FFF_FFFF);
    send_command(CMD_INSERT_MID, 7'd64, '1);
    send_command(CMD_INSERT_AT, 7'd3, '0);
    send_command(CMD_INSERT_AT, 7'd0, 32'h5555_5555);
    send_command(CMD_READ_AT, 7'd0, '0);
    send_command(CMD_READ_AT, 7'd2, '0);
    send_command(CMD_READ_AT, 7'd4, '0);
    send_command(CMD_READ_AT, 7'd127, '0);
    send_command(CMD_READ_AT, 7'd5, '0);
    send_command(CMD_REMOVE_AT, 7'd5, '0);
    send_command(CMD_REMOVE_AT, 7'd4, '0);
    send_command(CMD_REMOVE_AT, 7'd0, '0);
    send_command(CMD_REMOVE_MID, 7'd0, '0);
    send_command(CMD_POP, 7'd0, '0);
    send_command(CMD_READ_AT, 7'd0, '0);
    send_command(CMD_POP, 7'd0, '0);
    send_command(CMD_POP, 7'd0, '0);
  endtask

  // Fill the list to capacity, hit the full cases, then drain it to empty.
  task automatic test_fill_and_drain();
    logic [CMD_W-1:0] op;
    while (shadow_count < CAPACITY) begin
      case ($urandom_range(2))
        0: op = CMD_PUSH;
        1: op = CMD_INSERT_AT;
        default: op = CMD_INSERT_MID;
      endcase
      send_command(op, POS_W'($urandom_range(shadow_count, 0)), pick_word());
    end
    send_command(CMD_PUSH, pick_any_position(), pick_word());
    send_command(CMD_INSERT_AT, POS_W'(CAPACITY), pick_word());
    send_command(CMD_INSERT_AT, 7'd0, pick_word());
    send_command(CMD_INSERT_AT, 7'd127, pick_word());
    send_command(CMD_INSERT_MID, pick_any_position(), pick_word());
    send_command(CMD_READ_AT, POS_W'(CAPACITY - 1), pick_word());
    while (shadow_count > 0) begin
      case ($urandom_range(3))
        0: op = CMD_POP;
        1: op = CMD_REMOVE_AT;
        2: op = CMD_REMOVE_MID;
        default: op = CMD_READ_AT;
      endcase
      send_command(op, POS_W'($urandom_range(shadow_count - 1, 0)), pick_word());
    end
    send_command(CMD_POP, pick_any_position(), pick_word());
    send_command(CMD_REMOVE_MID, pick_any_position(), pick_word());
  endtask

  // Random traffic in stretches that alternately grow and shrink the list.
  task automatic test_random_traffic(int unsigned beats);
    logic [CMD_W-1:0] op;
    bit               grow;
    int unsigned      roll;
    for (int unsigned n = 0; n < beats; n++) begin
      if (n % 150 == 0) grow = (n / 150) % 2 == 0;
      roll = $urandom_range(99);
      if (roll < 4) begin
        op = CMD_UNKNOWN;
      end else if (roll < (grow ? 66 : 30)) begin
        case ($urandom_range(2))
          0: op = CMD_PUSH;
          1: op = CMD_INSERT_AT;
          default: op = CMD_INSERT_MID;
        endcase
      end else begin
        case ($urandom_range(3))
          0: op = CMD_POP;
          1: op = CMD_REMOVE_AT;
          2: op = CMD_REMOVE_MID;
          default: op = CMD_READ_AT;
        endcase
      end
      send_command(op, pick_position(op), pick_word());
    end
  endtask

  // Reset once, spread the tests over idle patterns, then wait for the last answers.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 21;
    test_edge_cases();
    test_fill_and_drain();
    test_random_traffic(600);

    sender_idle_pct = 68;
    test_random_traffic(600);

    sender_idle_pct = 0;
    test_random_traffic(600);
    test_fill_and_drain();

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
